/* hdl/itoa_pkg.sv */
// Shared constants and types for the integer to decimal ASCII unit.
`default_nettype none

package itoa_pkg;

    localparam int VALUE_BITS_W = 64;
    localparam int VALUE_WIDTH  = 64;
    localparam int NUM_DIGITS   = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W        = 4 * NUM_DIGITS;
    localparam int CNT_W        = $clog2(VALUE_WIDTH + 1);
    localparam int ND_W         = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W       = 7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_DABBLE,
        OP_DIGIT
    } t_bcd_op;

    typedef struct packed {
        t_bcd_op op;
        logic    neg;
    } t_bcd_ctl;

    typedef struct packed {
        logic [3:0] top_digit;
        logic       top_zero;
    } t_bcd_sts;

endpackage

`default_nettype wire

/* hdl/itoa_if.sv */
// Valid/ready channel interfaces for the value input and the character output.
`default_nettype none

interface itoa_in_if;
    logic                               valid;
    logic                               ready;
    logic [itoa_pkg::VALUE_BITS_W-1:0]  value_bits;
    logic                               is_signed;

    modport source (output valid, output value_bits, output is_signed, input ready);
    modport sink   (input valid, input value_bits, input is_signed, output ready);
endinterface

interface itoa_out_if;
    logic                           valid;
    logic                           ready;
    logic [itoa_pkg::CHAR_W-1:0]    char_code;
    logic                           last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

/* hdl/itoa_bcd_unit.sv */
// Shift-and-add-3 binary to BCD datapath with a digit shifter for output.
`default_nettype none

module itoa_bcd_unit (
    input  wire logic                              i_clk,
    input  wire itoa_pkg::t_bcd_ctl                i_ctl,
    input  wire logic [itoa_pkg::VALUE_WIDTH-1:0]  i_value,
    output itoa_pkg::t_bcd_sts                     o_sts
);

    logic [itoa_pkg::VALUE_WIDTH-1:0] r_bin;
    logic [itoa_pkg::VALUE_WIDTH-1:0] n_bin;
    logic [itoa_pkg::BCD_W-1:0]       r_bcd;
    logic [itoa_pkg::BCD_W-1:0]       n_bcd;
    logic [itoa_pkg::BCD_W-1:0]       adj;

    always_comb begin
        for (int k = 0; k < itoa_pkg::NUM_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        case (i_ctl.op)
            itoa_pkg::OP_LOAD: begin
                n_bin = i_ctl.neg ? (~i_value + 1'b1) : i_value;
                n_bcd = '0;
            end
            itoa_pkg::OP_DABBLE: begin
                n_bcd = {adj[itoa_pkg::BCD_W-2:0], r_bin[itoa_pkg::VALUE_WIDTH-1]};
                n_bin = {r_bin[itoa_pkg::VALUE_WIDTH-2:0], 1'b0};
            end
            itoa_pkg::OP_DIGIT: begin
                n_bcd = {r_bcd[itoa_pkg::BCD_W-5:0], 4'b0000};
            end
            default: begin
                n_bin = r_bin;
                n_bcd = r_bcd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_sts.top_digit = r_bcd[itoa_pkg::BCD_W-1 -: 4];
    assign o_sts.top_zero  = (r_bcd[itoa_pkg::BCD_W-1 -: 4] == 4'd0);

endmodule

`default_nettype wire

/* hdl/integer_to_decimal_ascii_unit.sv */
// Top level: converts one integer item into its decimal ASCII characters.
//
// Input channel i_in carries value_bits and is_signed; only the low
// VALUE_WIDTH bits of value_bits count, and is_signed marks them as two's
// complement. Output channel o_out carries one character item per handshake,
// most significant first, '-' leading a negative value, last_char on the
// final digit. Zero gives a single '0'.
//
// Steps per item: the magnitude is loaded on acceptance, then converted by
// shift-and-add-3 over every bit in the shared BCD unit; leading zero digits
// are trimmed one at a time down to a single digit, then the sign of a
// negative value and one digit per handshake are sent while the receiver
// keeps up. i_in.ready is high only while the unit is idle.
//
// A stall on o_out holds the current character in the output register and
// freezes the sequencer in its sign and digit states. The next item may be
// accepted while the final character still waits. Reset (i_rst_n low,
// synchronous) empties the output register and returns the sequencer to idle.
`default_nettype none

module integer_to_decimal_ascii_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    itoa_in_if.sink     i_in,
    itoa_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_TRIM,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state                         r_state;
    logic [itoa_pkg::CNT_W-1:0]     r_cnt;
    logic [itoa_pkg::ND_W-1:0]      r_nd;
    logic                           r_neg;
    logic                           r_out_valid;
    logic [itoa_pkg::CHAR_W-1:0]    r_out_char;
    logic                           r_out_last;

    itoa_pkg::t_bcd_ctl             bcd_ctl;
    itoa_pkg::t_bcd_sts             bcd_sts;
    logic                           in_fire;
    logic                           can_load;
    logic                           out_load;
    logic                           in_neg;

    assign in_fire  = i_in.valid && i_in.ready;
    assign can_load = !r_out_valid || o_out.ready;
    assign out_load = (r_state == S_SIGN || r_state == S_EMIT) && can_load;
    assign in_neg   = i_in.is_signed && i_in.value_bits[itoa_pkg::VALUE_WIDTH-1];

    always_comb begin
        bcd_ctl.neg = in_neg;
        bcd_ctl.op  = itoa_pkg::OP_HOLD;
        case (r_state)
            S_IDLE: if (in_fire) bcd_ctl.op = itoa_pkg::OP_LOAD;
            S_CONV: bcd_ctl.op = itoa_pkg::OP_DABBLE;
            S_TRIM: begin
                if (bcd_sts.top_zero && r_nd > itoa_pkg::ND_W'(1)) begin
                    bcd_ctl.op = itoa_pkg::OP_DIGIT;
                end
            end
            S_EMIT: if (can_load) bcd_ctl.op = itoa_pkg::OP_DIGIT;
            default: bcd_ctl.op = itoa_pkg::OP_HOLD;
        endcase
    end

    itoa_bcd_unit u_bcd (
        .i_clk   (i_clk),
        .i_ctl   (bcd_ctl),
        .i_value (i_in.value_bits[itoa_pkg::VALUE_WIDTH-1:0]),
        .o_sts   (bcd_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_nd        <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_neg   <= in_neg;
                        r_cnt   <= itoa_pkg::CNT_W'(itoa_pkg::VALUE_WIDTH);
                        r_nd    <= itoa_pkg::ND_W'(itoa_pkg::NUM_DIGITS);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == itoa_pkg::CNT_W'(1)) begin
                        r_state <= S_TRIM;
                    end
                end
                S_TRIM: begin
                    if (bcd_sts.top_zero && r_nd > itoa_pkg::ND_W'(1)) begin
                        r_nd <= r_nd - 1'b1;
                    end else begin
                        r_state <= r_neg ? S_SIGN : S_EMIT;
                    end
                end
                S_SIGN: begin
                    if (can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= itoa_pkg::CHAR_MINUS;
                        r_out_last  <= 1'b0;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= itoa_pkg::CHAR_ZERO + {3'b000, bcd_sts.top_digit};
                        r_out_last  <= (r_nd == itoa_pkg::ND_W'(1));
                        r_nd        <= r_nd - 1'b1;
                        if (r_nd == itoa_pkg::ND_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_char;
    assign o_out.last_char = r_out_last;

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_CONV))
        else $error("accepted item did not start conversion");

    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM || r_state == S_SIGN || r_state == S_EMIT) |-> (r_nd != '0))
        else $error("digit count ran out before the last character");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && can_load && r_nd == itoa_pkg::ND_W'(1))
        |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final character not marked or sequencer not idle");

    a_lead_digit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_TRIM && r_state != S_TRIM && r_nd > itoa_pkg::ND_W'(1))
        |-> !bcd_sts.top_zero)
        else $error("leading zero digit left after trimming");

endmodule

`default_nettype wire

/* verif/integer_to_decimal_ascii_unit_tb.sv */
// Self-checking testbench for the integer to decimal ASCII unit.
`default_nettype none

module integer_to_decimal_ascii_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 120;

    typedef logic [itoa_pkg::VALUE_BITS_W-1:0] t_value;

    typedef struct packed {
        logic [itoa_pkg::CHAR_W-1:0] char_code;
        logic                        last_char;
    } t_char_item;

    localparam t_value WIDTH_MASK = {itoa_pkg::VALUE_BITS_W{1'b1}}
                                    >> (itoa_pkg::VALUE_BITS_W - itoa_pkg::VALUE_WIDTH);

    logic i_clk = 1'b0;
    logic i_rst_n;

    itoa_in_if  in_if ();
    itoa_out_if out_if ();

    integer_to_decimal_ascii_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_char_item expected_chars[$];
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         hold_requests  = 0;
    int         holds_started  = 0;
    int         hold_left      = 0;
    int         fail_count     = 0;
    int         values_sent    = 0;
    int         signed_sent    = 0;
    int         negatives_sent = 0;
    int         chars_checked  = 0;
    int         cycle_count    = 0;

    always #5 i_clk = ~i_clk;

    // Decimal text of one value, most significant character first
    function automatic void predict_text(input t_value raw, input logic sgn);
        t_value     mag;
        logic       neg;
        logic [3:0] digits[$];
        t_char_item ch;
        mag = raw & WIDTH_MASK;
        neg = sgn && mag[itoa_pkg::VALUE_WIDTH-1];
        if (neg) begin
            mag = (t_value'(0) - mag) & WIDTH_MASK;
            ch.char_code = itoa_pkg::CHAR_MINUS;
            ch.last_char = 1'b0;
            expected_chars.push_back(ch);
            negatives_sent++;
        end
        do begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        foreach (digits[i]) begin
            ch.char_code = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(digits[i]);
            ch.last_char = (i == digits.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            predict_text(in_if.value_bits, in_if.is_signed);
            values_sent++;
            if (in_if.is_signed)
                signed_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_char_item exp_ch;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character item: char_code=0x%0h last_char=%0b",
                       out_if.char_code, out_if.last_char);
                fail_count++;
            end else begin
                exp_ch = expected_chars.pop_front();
                chars_checked++;
                if (out_if.char_code !== exp_ch.char_code) begin
                    $error("char_code: expected 0x%0h, got 0x%0h",
                           exp_ch.char_code, out_if.char_code);
                    fail_count++;
                end
                if (out_if.last_char !== exp_ch.last_char) begin
                    $error("last_char: expected %0b, got %0b",
                           exp_ch.last_char, out_if.last_char);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_requests != holds_started) begin
            holds_started <= holds_started + 1;
            hold_left     <= HOLD_CYCLES;
            out_if.ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("integer_to_decimal_ascii_unit verification failed");
            $finish;
        end
    end

    task automatic send_value(input t_value raw, input logic sgn);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.value_bits <= raw;
        in_if.is_signed  <= sgn;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // One edge first so the item accepted at the last edge is already predicted
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_value power_of_ten(input int k);
        t_value p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    function automatic t_value pick_value();
        t_value full;
        int     len;
        full = {$urandom, $urandom};
        case ($urandom_range(5))
            0: return full;
            1: begin
                len = $urandom_range(1, itoa_pkg::VALUE_BITS_W);
                return full & ({itoa_pkg::VALUE_BITS_W{1'b1}}
                               >> (itoa_pkg::VALUE_BITS_W - len));
            end
            2: return power_of_ten($urandom_range(19)) + $urandom_range(2) - 1;
            3: return t_value'(0) - (full & t_value'($urandom_range(1, 1000000)));
            4: return {$urandom_range(1) == 1,
                       {(itoa_pkg::VALUE_BITS_W-1){$urandom_range(1) == 1}}}
                      ^ t_value'($urandom_range(3));
            default: return t_value'($urandom_range(20));
        endcase
    endfunction

    task automatic test_directed_edges();
        t_value all_ones;
        t_value min_neg;
        all_ones = '1;
        min_neg  = t_value'(1) << (itoa_pkg::VALUE_WIDTH - 1);
        send_value('0, 1'b0);
        send_value('0, 1'b1);
        send_value(all_ones, 1'b0);
        send_value(all_ones, 1'b1);
        send_value(min_neg, 1'b1);
        send_value(min_neg, 1'b0);
        send_value(min_neg - 1, 1'b1);
        send_value(min_neg - 1, 1'b0);
        send_value(t_value'(1), 1'b1);
        send_value(t_value'(9), 1'b0);
        send_value(t_value'(10), 1'b0);
        send_value(t_value'(99), 1'b1);
        send_value(t_value'(100), 1'b1);
        send_value(power_of_ten(19) - 1, 1'b0);
        send_value(power_of_ten(19), 1'b0);
        send_value(power_of_ten(18) - 1, 1'b1);
        send_value(power_of_ten(18), 1'b1);
        send_value(all_ones - 8, 1'b1);
        send_value(all_ones - 9, 1'b1);
        send_value(all_ones - 1, 1'b0);
        send_value(t_value'(5), 1'b0);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_value(pick_value(), $urandom_range(1) == 1);
    endtask

    // Output held off while values keep coming, so the unit fills and stops taking input
    task automatic test_output_stall();
        hold_requests++;
        repeat (6) send_value(pick_value(), $urandom_range(1) == 1);
    endtask

    task automatic test_drain_pause();
        repeat (5) send_value(pick_value(), $urandom_range(1) == 1);
        wait_for_drain();
        repeat (5) send_value(pick_value(), $urandom_range(1) == 1);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.value_bits = '0;
        in_if.is_signed  = 1'b0;
        tx_idle_pct      = 33;
        rx_idle_pct      = 69;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_random_mix(80);
        test_output_stall();

        tx_idle_pct = 69;
        rx_idle_pct = 33;
        test_random_mix(80);
        test_drain_pause();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_mix(80);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Converted %0d values (%0d signed, %0d negative), %0d characters checked",
                 values_sent, signed_sent, negatives_sent, chars_checked);
        $display("Included extremes, powers of ten, long output stall and varied idling");
        if (fail_count == 0) begin
            $display("integer_to_decimal_ascii_unit verification clean");
        end else begin
            $display("integer_to_decimal_ascii_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
